// ===== rtl/sync_ack_burst_tx_sequencer_unit_macros.svh =====
// ----------------------------------------------------------------------------
// sync ack burst tx sequencer assertion macros
// shared concurrent assertion forms, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef SYNC_ACK_BURST_TX_SEQUENCER_UNIT_MACROS_SVH
`define SYNC_ACK_BURST_TX_SEQUENCER_UNIT_MACROS_SVH

`ifndef SYNTH
`define SATS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");
`define SATS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SATS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SATS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/sats_pkg.sv =====
// ----------------------------------------------------------------------------
// sats_pkg
// types and constants shared by the sync ack burst tx sequencer
// ----------------------------------------------------------------------------
package sats_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] CFG_CYCLE_PERIOD  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ACK_TIMEOUT   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_RESP_WAIT     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_LIMIT  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_EXP_ACK0      = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_EXP_ACK1      = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] CFG_EXP_ACK2      = 3'd6;

	localparam logic [15:0] RST_CYCLE_PERIOD = 16'd500;
	localparam logic [15:0] RST_ACK_TIMEOUT  = 16'd2;
	localparam logic [15:0] RST_RESP_WAIT    = 16'd4;
	localparam logic [7:0]  RST_REPEAT_LIMIT = 8'd5;
	localparam logic [7:0]  RST_EXP_ACK0     = 8'h41;
	localparam logic [7:0]  RST_EXP_ACK1     = 8'h43;
	localparam logic [7:0]  RST_EXP_ACK2     = 8'h4B;

	localparam logic [1:0] FUNC_TICK    = 2'd0;
	localparam logic [1:0] FUNC_TX_DONE = 2'd1;
	localparam logic [1:0] FUNC_RX_DONE = 2'd2;

	localparam logic [3:0] CMD_TX_SYNC     = 4'd0;
	localparam logic [3:0] CMD_TX_END      = 4'd1;
	localparam logic [3:0] CMD_RX_START    = 4'd2;
	localparam logic [3:0] CMD_RX_END      = 4'd3;
	localparam logic [3:0] CMD_SCHED_EN    = 4'd4;
	localparam logic [3:0] CMD_TX_BURST    = 4'd5;
	localparam logic [3:0] CMD_SCHED_CFG   = 4'd6;
	localparam logic [3:0] CMD_TX_RESTART  = 4'd7;
	localparam logic [3:0] CMD_SCHED_DIS   = 4'd8;
	localparam logic [3:0] CMD_CYCLE_DONE  = 4'd9;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SYNC_TX_WAIT,
		PH_ACK_WAIT,
		PH_RESP_WAIT,
		PH_BURST_WAIT
	} phase_t;

	typedef struct packed {
		logic [1:0] func;
		logic       rx_ok;
		logic [7:0] rx_byte0;
		logic [7:0] rx_byte1;
		logic [7:0] rx_byte2;
	} in_item_t;

	typedef struct packed {
		logic [3:0] command;
		logic [7:0] burst_index;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic [1:0] cnt;
		logic [3:0] cmd0;
		logic [3:0] cmd1;
		logic [3:0] cmd2;
		logic [7:0] burst_index;
	} job_t;

	typedef struct packed {
		logic push;
		job_t job;
	} push_req_t;

endpackage

// ===== rtl/sync_ack_burst_tx_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// sync_ack_burst_tx_sequencer_unit
// initiator sync, ack and burst sequencer: events in, radio commands out
// ----------------------------------------------------------------------------
// the first command of an event passes the job queue, the back end's job register
// and the output register; one event per cycle in while the queue has room; the
// back end issues one command per cycle while not stalled, up to three per event
// a two-entry job queue lets events be taken while earlier commands drain
// reset: phase idle, timer saturated so the first event starts a cycle,
// pending flags, burst count and queue cleared, registers at their defaults
module sync_ack_burst_tx_sequencer_unit #(
	parameter int TIMER_WIDTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  sats_pkg::in_item_t               in_item,
	output logic                             in_stall,
	output logic                             out_valid,
	output sats_pkg::out_item_t              out_item,
	input  logic                             out_stall,
	input  logic                             cfg_we,
	input  logic [sats_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [sats_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import sats_pkg::*;

	push_req_t push_req;
	logic      q_full;
	logic      q_valid;
	job_t      q_job;
	logic      pop;

	sats_front #(
		.TIMER_WIDTH(TIMER_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_item  (in_item),
		.in_stall (in_stall),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.q_full   (q_full),
		.push_req (push_req)
	);

	sats_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push_req(push_req),
		.full    (q_full),
		.q_valid (q_valid),
		.q_job   (q_job),
		.pop     (pop)
	);

	sats_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_job    (q_job),
		.pop      (pop),
		.out_valid(out_valid),
		.out_item (out_item),
		.out_stall(out_stall)
	);

endmodule

// ===== rtl/sats_front.sv =====
// ----------------------------------------------------------------------------
// sats_front
// accepts events, keeps the timer, pending flags and phase, and turns each
// event into a job of up to three radio commands
// ----------------------------------------------------------------------------
module sats_front #(
	parameter int TIMER_WIDTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  sats_pkg::in_item_t                 in_item,
	output logic                               in_stall,
	input  logic                               cfg_we,
	input  logic [sats_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [sats_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               q_full,
	output sats_pkg::push_req_t                push_req
);
	import sats_pkg::*;

	localparam int CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

	logic [15:0] cycle_period_q;
	logic [15:0] ack_timeout_q;
	logic [15:0] resp_wait_q;
	logic [7:0]  repeat_limit_q;
	logic [7:0]  exp_ack0_q;
	logic [7:0]  exp_ack1_q;
	logic [7:0]  exp_ack2_q;

	phase_t                 phase_q, phase_d;
	logic [TIMER_WIDTH-1:0] elapsed_q, elapsed_d;
	logic [7:0]             burst_q, burst_d;
	logic                   tx_pend_q, tx_pend_d;
	logic                   rx_pend_q, rx_pend_d;
	logic                   ack_good_q, ack_good_d;
	logic                   in_fire;
	logic [CMP_W-1:0]       el_ext;
	logic [8:0]             burst_next;
	job_t                   job;

	assign in_stall = q_full;
	assign in_fire  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_period_q <= RST_CYCLE_PERIOD;
			ack_timeout_q  <= RST_ACK_TIMEOUT;
			resp_wait_q    <= RST_RESP_WAIT;
			repeat_limit_q <= RST_REPEAT_LIMIT;
			exp_ack0_q     <= RST_EXP_ACK0;
			exp_ack1_q     <= RST_EXP_ACK1;
			exp_ack2_q     <= RST_EXP_ACK2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CYCLE_PERIOD: cycle_period_q <= cfg_data;
				CFG_ACK_TIMEOUT:  ack_timeout_q  <= cfg_data;
				CFG_RESP_WAIT:    resp_wait_q    <= cfg_data;
				CFG_REPEAT_LIMIT: repeat_limit_q <= cfg_data[7:0];
				CFG_EXP_ACK0:     exp_ack0_q     <= cfg_data[7:0];
				CFG_EXP_ACK1:     exp_ack1_q     <= cfg_data[7:0];
				CFG_EXP_ACK2:     exp_ack2_q     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			elapsed_q  <= '1;
			burst_q    <= '0;
			tx_pend_q  <= 1'b0;
			rx_pend_q  <= 1'b0;
			ack_good_q <= 1'b0;
		end else if (in_fire) begin
			phase_q    <= phase_d;
			elapsed_q  <= elapsed_d;
			burst_q    <= burst_d;
			tx_pend_q  <= tx_pend_d;
			rx_pend_q  <= rx_pend_d;
			ack_good_q <= ack_good_d;
		end
	end

	always_comb begin
		elapsed_d  = elapsed_q;
		tx_pend_d  = tx_pend_q;
		rx_pend_d  = rx_pend_q;
		ack_good_d = ack_good_q;
		burst_d    = burst_q;
		phase_d    = phase_q;
		job        = '0;

		// event update before the phase acts
		case (in_item.func)
			FUNC_TICK: begin
				if (elapsed_q != '1) begin
					elapsed_d = elapsed_q + TIMER_WIDTH'(1);
				end
			end
			FUNC_TX_DONE: tx_pend_d = 1'b1;
			FUNC_RX_DONE: begin
				rx_pend_d  = 1'b1;
				ack_good_d = in_item.rx_ok && (in_item.rx_byte0 == exp_ack0_q)
					&& (in_item.rx_byte1 == exp_ack1_q)
					&& (in_item.rx_byte2 == exp_ack2_q);
			end
			default: ;
		endcase

		el_ext     = CMP_W'(elapsed_d);
		burst_next = {1'b0, burst_q} + 9'd1;

		unique case (phase_q)
			PH_IDLE: begin
				if (el_ext >= CMP_W'(cycle_period_q)) begin
					job.cnt  = 2'd1;
					job.cmd0 = CMD_TX_SYNC;
					phase_d  = PH_SYNC_TX_WAIT;
				end
			end
			PH_SYNC_TX_WAIT: begin
				if (tx_pend_d) begin
					tx_pend_d = 1'b0;
					job.cnt   = 2'd2;
					job.cmd0  = CMD_TX_END;
					job.cmd1  = CMD_RX_START;
					elapsed_d = '0;
					phase_d   = PH_ACK_WAIT;
				end
			end
			PH_ACK_WAIT: begin
				if (el_ext >= CMP_W'(ack_timeout_q)) begin
					job.cnt  = 2'd2;
					job.cmd0 = CMD_RX_END;
					job.cmd1 = CMD_TX_SYNC;
					phase_d  = PH_SYNC_TX_WAIT;
				end else if (rx_pend_d) begin
					rx_pend_d = 1'b0;
					job.cmd0  = CMD_RX_END;
					if (ack_good_d) begin
						job.cnt   = 2'd1;
						elapsed_d = '0;
						phase_d   = PH_RESP_WAIT;
					end else begin
						job.cnt  = 2'd2;
						job.cmd1 = CMD_TX_SYNC;
						phase_d  = PH_SYNC_TX_WAIT;
					end
				end
			end
			PH_RESP_WAIT: begin
				if (el_ext >= CMP_W'(resp_wait_q)) begin
					job.cnt  = 2'd2;
					job.cmd0 = CMD_SCHED_EN;
					job.cmd1 = CMD_TX_BURST;
					phase_d  = PH_BURST_WAIT;
				end
			end
			PH_BURST_WAIT: begin
				if (tx_pend_d) begin
					tx_pend_d = 1'b0;
					if (burst_next <= {1'b0, repeat_limit_q}) begin
						burst_d  = burst_next[7:0];
						job.cnt  = 2'd2;
						job.cmd0 = CMD_SCHED_CFG;
						job.cmd1 = CMD_TX_RESTART;
					end else begin
						burst_d   = '0;
						job.cnt   = 2'd3;
						job.cmd0  = CMD_SCHED_DIS;
						job.cmd1  = CMD_TX_END;
						job.cmd2  = CMD_CYCLE_DONE;
						elapsed_d = '0;
						phase_d   = PH_IDLE;
					end
				end
			end
			default: phase_d = PH_IDLE;
		endcase

		job.burst_index = burst_d;
	end

	assign push_req.push = in_fire && (job.cnt != 2'd0);
	assign push_req.job  = job;

endmodule

// ===== rtl/sats_queue.sv =====
// ----------------------------------------------------------------------------
// sats_queue
// two-entry job queue between the event front and the command back end
// ----------------------------------------------------------------------------
`include "sync_ack_burst_tx_sequencer_unit_macros.svh"

module sats_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  sats_pkg::push_req_t push_req,
	output logic                full,
	output logic                q_valid,
	output sats_pkg::job_t      q_job,
	input  logic                pop
);
	import sats_pkg::*;

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full    = (count_q == (PTR_W+1)'(DEPTH));
	assign q_valid = (count_q != '0);
	assign q_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_req.push) begin
			mem_q[wr_ptr_q] <= push_req.job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_req.push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			case ({push_req.push, pop})
				2'b10:   count_q <= count_q + (PTR_W+1)'(1);
				2'b01:   count_q <= count_q - (PTR_W+1)'(1);
				default: ;
			endcase
		end
	end

	`SATS_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= (PTR_W+1)'(DEPTH))
	`SATS_ASSERT_IMPL(a_no_overflow, clk, arst_n, push_req.push, !full || pop)
	`SATS_ASSERT_IMPL(a_no_underflow, clk, arst_n, pop, q_valid)

endmodule

// ===== rtl/sats_back.sv =====
// ----------------------------------------------------------------------------
// sats_back
// takes jobs from the queue and issues their commands one per cycle through
// the output register while not stalled, marking each job's final command
// ----------------------------------------------------------------------------
`include "sync_ack_burst_tx_sequencer_unit_macros.svh"

module sats_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  sats_pkg::job_t      q_job,
	output logic                pop,
	output logic                out_valid,
	output sats_pkg::out_item_t out_item,
	input  logic                out_stall
);
	import sats_pkg::*;

	job_t      job_q;
	logic      have_job_q;
	logic [1:0] idx_q;
	logic      out_valid_q;
	out_item_t out_item_q;
	logic      adv;
	logic      job_last;
	logic [3:0] cur_cmd;

	assign adv      = !out_valid_q || !out_stall;
	assign job_last = (idx_q == job_q.cnt - 2'd1);
	assign pop      = q_valid && (!have_job_q || (adv && job_last));

	always_comb begin
		case (idx_q)
			2'd0:    cur_cmd = job_q.cmd0;
			2'd1:    cur_cmd = job_q.cmd1;
			default: cur_cmd = job_q.cmd2;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_job_q  <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= have_job_q;
			end
			if (pop) begin
				have_job_q <= 1'b1;
				idx_q      <= '0;
			end else if (adv && have_job_q) begin
				if (job_last) begin
					have_job_q <= 1'b0;
				end
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= q_job;
		end
		if (adv && have_job_q) begin
			out_item_q.command     <= cur_cmd;
			out_item_q.burst_index <= job_q.burst_index;
			out_item_q.last        <= job_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	`SATS_ASSERT_IMPL(a_idx_in_job, clk, arst_n, have_job_q, idx_q < job_q.cnt)
	`SATS_ASSERT_IMPL(a_job_nonempty, clk, arst_n, have_job_q, job_q.cnt != 2'd0)
	`SATS_ASSERT_NEXT(a_last_drops_job, clk, arst_n,
		adv && have_job_q && job_last && !pop, !have_job_q)

endmodule

// ===== bench/tb_sync_ack_burst_tx_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_sync_ack_burst_tx_sequencer_unit
// drives tick and done events into the sequencer and checks every radio
// command against an in-bench model of the sync, ack and burst cycle; a
// directed opening covers the corner cases, then register settings change
// between phases of mostly well-formed random traffic, most under random stalls
// ----------------------------------------------------------------------------
module tb_sync_ack_burst_tx_sequencer_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import sats_pkg::*;

	localparam int TIMER_W = 16;
	localparam logic [1:0] FUNC_NONE = 2'd3;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES = 80;
	localparam int PHASE_ITEMS = 18;
	localparam int RANDOM_PHASES = 9;
	localparam int BIG_BURST_CAP = 60;

	class radio_cmd_tracker;
		logic [15:0] period_ms, ack_to_ms, resp_ms;
		logic [7:0] rep_lim, ack_b0, ack_b1, ack_b2;
		phase_t phase;
		logic [TIMER_W-1:0] elapsed;
		logic [7:0] bursts;
		bit tx_pend, rx_pend, ack_ok;
		out_item_t cmds_due[$];
		int errors;
		int cycles_done;

		function new();
			period_ms = RST_CYCLE_PERIOD;
			ack_to_ms = RST_ACK_TIMEOUT;
			resp_ms = RST_RESP_WAIT;
			rep_lim = RST_REPEAT_LIMIT;
			ack_b0 = RST_EXP_ACK0;
			ack_b1 = RST_EXP_ACK1;
			ack_b2 = RST_EXP_ACK2;
			phase = PH_IDLE;
			elapsed = '1;
			bursts = '0;
			tx_pend = 0;
			rx_pend = 0;
			ack_ok = 0;
			errors = 0;
			cycles_done = 0;
		endfunction

		function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_CYCLE_PERIOD: period_ms = val;
				CFG_ACK_TIMEOUT: ack_to_ms = val;
				CFG_RESP_WAIT: resp_ms = val;
				CFG_REPEAT_LIMIT: rep_lim = val[7:0];
				CFG_EXP_ACK0: ack_b0 = val[7:0];
				CFG_EXP_ACK1: ack_b1 = val[7:0];
				CFG_EXP_ACK2: ack_b2 = val[7:0];
				default: ;
			endcase
		endfunction

		function void note_event(in_item_t ev);
			logic [3:0] cmds[$];
			logic [8:0] next_count;
			out_item_t res;
			case (ev.func)
				FUNC_TICK: if (elapsed != '1) elapsed++;
				FUNC_TX_DONE: tx_pend = 1;
				FUNC_RX_DONE: begin
					rx_pend = 1;
					ack_ok = ev.rx_ok && ev.rx_byte0 == ack_b0 &&
						ev.rx_byte1 == ack_b1 && ev.rx_byte2 == ack_b2;
				end
				default: ;
			endcase
			case (phase)
				PH_IDLE: if (elapsed >= period_ms) begin
					cmds.push_back(CMD_TX_SYNC);
					phase = PH_SYNC_TX_WAIT;
				end
				PH_SYNC_TX_WAIT: if (tx_pend) begin
					tx_pend = 0;
					cmds.push_back(CMD_TX_END);
					cmds.push_back(CMD_RX_START);
					elapsed = '0;
					phase = PH_ACK_WAIT;
				end
				PH_ACK_WAIT: if (elapsed >= ack_to_ms) begin
					cmds.push_back(CMD_RX_END);
					cmds.push_back(CMD_TX_SYNC);
					phase = PH_SYNC_TX_WAIT;
				end else if (rx_pend) begin
					rx_pend = 0;
					cmds.push_back(CMD_RX_END);
					if (ack_ok) begin
						elapsed = '0;
						phase = PH_RESP_WAIT;
					end else begin
						cmds.push_back(CMD_TX_SYNC);
						phase = PH_SYNC_TX_WAIT;
					end
				end
				PH_RESP_WAIT: if (elapsed >= resp_ms) begin
					cmds.push_back(CMD_SCHED_EN);
					cmds.push_back(CMD_TX_BURST);
					phase = PH_BURST_WAIT;
				end
				PH_BURST_WAIT: if (tx_pend) begin
					tx_pend = 0;
					next_count = {1'b0, bursts} + 9'd1;
					if (next_count <= {1'b0, rep_lim}) begin
						bursts = next_count[7:0];
						cmds.push_back(CMD_SCHED_CFG);
						cmds.push_back(CMD_TX_RESTART);
					end else begin
						bursts = '0;
						cmds.push_back(CMD_SCHED_DIS);
						cmds.push_back(CMD_TX_END);
						cmds.push_back(CMD_CYCLE_DONE);
						elapsed = '0;
						phase = PH_IDLE;
						cycles_done++;
					end
				end
				default: phase = PH_IDLE;
			endcase
			foreach (cmds[k]) begin
				res.command = cmds[k];
				res.burst_index = bursts;
				res.last = (k == cmds.size() - 1);
				cmds_due.push_back(res);
			end
		endfunction

		function void check_command(out_item_t got);
			out_item_t want;
			if (cmds_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected command cmd=%0d idx=%0d last=%0d",
						got.command, got.burst_index, got.last);
				return;
			end
			want = cmds_due.pop_front();
			if (got.command !== want.command || got.burst_index !== want.burst_index ||
					got.last !== want.last) begin
				errors++;
				if (errors <= 10)
					$display("command mismatch: want cmd=%0d idx=%0d last=%0d, ",
						want.command, want.burst_index, want.last,
						"got cmd=%0d idx=%0d last=%0d",
						got.command, got.burst_index, got.last);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	in_item_t in_item;
	logic in_stall;
	logic out_valid;
	out_item_t out_item;
	logic out_stall;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	radio_cmd_tracker sb;
	logic [CFG_DATA_W-1:0] reg_plan [7];
	int send_idle_pct;
	int recv_idle_pct;
	int hold_asked;
	int hold_served;
	int hold_left;

	sync_ack_burst_tx_sequencer_unit #(
		.TIMER_WIDTH(TIMER_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_item(in_item),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_item(out_item),
		.out_stall(out_stall),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	// result side: check accepted commands, then pick the next stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_command(out_item);
		if (hold_served != hold_asked) begin
			hold_served = hold_asked;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	function automatic in_item_t make_ev(logic [1:0] f, logic ok, logic [7:0] b0,
			logic [7:0] b1, logic [7:0] b2);
		in_item_t ev;
		ev.func = f;
		ev.rx_ok = ok;
		ev.rx_byte0 = b0;
		ev.rx_byte1 = b1;
		ev.rx_byte2 = b2;
		return ev;
	endfunction

	// mostly the event that the current step waits for, some noise
	function automatic in_item_t pick_event(bit clean);
		in_item_t ev;
		int roll;
		ev = make_ev(FUNC_TICK, 1'($urandom_range(1)), 8'($urandom), 8'($urandom),
			8'($urandom));
		roll = $urandom_range(99);
		if (!clean && roll < 15) begin
			ev.func = 2'($urandom_range(3));
			return ev;
		end
		case (sb.phase)
			PH_SYNC_TX_WAIT, PH_BURST_WAIT:
				if (clean || roll < 85) ev.func = FUNC_TX_DONE;
			PH_ACK_WAIT: if (clean || roll < 70) begin
				ev.func = FUNC_RX_DONE;
				ev.rx_ok = 1'b1;
				ev.rx_byte0 = sb.ack_b0;
				ev.rx_byte1 = sb.ack_b1;
				ev.rx_byte2 = sb.ack_b2;
				if (!clean && $urandom_range(99) < 35) begin
					case ($urandom_range(3))
						0: ev.rx_ok = 1'b0;
						1: ev.rx_byte0 ^= 8'(1 << $urandom_range(7));
						2: ev.rx_byte1 ^= 8'(1 << $urandom_range(7));
						default: ev.rx_byte2 ^= 8'(1 << $urandom_range(7));
					endcase
				end
			end
			default: ev.func = FUNC_TICK;
		endcase
		return ev;
	endfunction

	task automatic send_event(in_item_t ev);
		in_valid <= 1'b1;
		in_item <= ev;
		do @(posedge clk); while (in_stall);
		sb.note_event(ev);
	endtask

	task automatic pause_sender();
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic run_events(int count);
		for (int i = 0; i < count; i++) begin
			send_event(pick_event(1'b0));
			pause_sender();
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.cmds_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apply_regs(bit [6:0] sel);
		for (int i = 0; i < 7; i++) begin
			if (sel[i]) begin
				cfg_we <= 1'b1;
				cfg_index <= CFG_INDEX_W'(i);
				cfg_data <= reg_plan[i];
				@(posedge clk);
				sb.set_reg(CFG_INDEX_W'(i), reg_plan[i]);
			end
		end
		cfg_we <= 1'b0;
	endtask

	task automatic plan_regs(int k);
		reg_plan[CFG_CYCLE_PERIOD] = 16'($urandom_range(5));
		reg_plan[CFG_ACK_TIMEOUT] = 16'($urandom_range(1, 5));
		reg_plan[CFG_RESP_WAIT] = 16'($urandom_range(4));
		reg_plan[CFG_REPEAT_LIMIT] = {8'($urandom), 8'($urandom_range(4))};
		reg_plan[CFG_EXP_ACK0] = 16'($urandom);
		reg_plan[CFG_EXP_ACK1] = 16'($urandom);
		reg_plan[CFG_EXP_ACK2] = 16'($urandom);
		case (k)
			0: begin
				reg_plan[CFG_CYCLE_PERIOD] = '0;
				reg_plan[CFG_ACK_TIMEOUT] = '0;
				reg_plan[CFG_RESP_WAIT] = '0;
				reg_plan[CFG_REPEAT_LIMIT][7:0] = '0;
			end
			1: reg_plan[CFG_ACK_TIMEOUT] = '1;
			2: reg_plan[CFG_RESP_WAIT] = '1;
			3: begin
				reg_plan[CFG_EXP_ACK0][7:0] = 8'h00;
				reg_plan[CFG_EXP_ACK1][7:0] = 8'h00;
				reg_plan[CFG_EXP_ACK2][7:0] = 8'h00;
			end
			4: begin
				reg_plan[CFG_EXP_ACK0][7:0] = 8'hFF;
				reg_plan[CFG_EXP_ACK1][7:0] = 8'hFF;
				reg_plan[CFG_EXP_ACK2][7:0] = 8'hFF;
				reg_plan[CFG_REPEAT_LIMIT][7:0] = '0;
			end
			default: ;
		endcase
	endtask

	initial begin
		int start_cycles;
		int sent;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_asked = 0;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// top cycle period still met by the saturated timer
		reg_plan[CFG_CYCLE_PERIOD] = '1;
		apply_regs(7'(1 << CFG_CYCLE_PERIOD));
		send_event(make_ev(FUNC_TICK, 1'b0, 8'h00, 8'h00, 8'h00));
		send_event(make_ev(FUNC_NONE, 1'b1, 8'hFF, 8'hFF, 8'hFF));
		send_event(make_ev(FUNC_TX_DONE, 1'b0, 8'h00, 8'h00, 8'h00));
		// bad status, then bad bytes
		send_event(make_ev(FUNC_RX_DONE, 1'b0, RST_EXP_ACK0, RST_EXP_ACK1, RST_EXP_ACK2));
		send_event(make_ev(FUNC_TX_DONE, 1'b0, 8'h00, 8'h00, 8'h00));
		send_event(make_ev(FUNC_RX_DONE, 1'b1, 8'hFF, 8'hFF, 8'hFF));
		send_event(make_ev(FUNC_TX_DONE, 1'b0, 8'h00, 8'h00, 8'h00));
		// ack timeout
		repeat (2) send_event(make_ev(FUNC_TICK, 1'b0, 8'h00, 8'h00, 8'h00));
		// good ack arrives early and waits
		send_event(make_ev(FUNC_RX_DONE, 1'b1, RST_EXP_ACK0, RST_EXP_ACK1, RST_EXP_ACK2));
		send_event(make_ev(FUNC_TX_DONE, 1'b0, 8'h00, 8'h00, 8'h00));
		send_event(make_ev(FUNC_TICK, 1'b0, 8'h00, 8'h00, 8'h00));
		send_event(make_ev(FUNC_RX_DONE, 1'b1, 8'h00, 8'h00, 8'h00));
		repeat (4) send_event(make_ev(FUNC_TICK, 1'b0, 8'h00, 8'h00, 8'h00));
		repeat (6) send_event(make_ev(FUNC_TX_DONE, 1'b0, 8'h00, 8'h00, 8'h00));
		send_event(make_ev(FUNC_TICK, 1'b0, 8'h00, 8'h00, 8'h00));
		// early tx done left pending in idle
		send_event(make_ev(FUNC_TX_DONE, 1'b1, 8'hFF, 8'hFF, 8'hFF));
		drain();

		for (int k = 0; k < RANDOM_PHASES; k++) begin
			case (k / 3)
				0: begin
					send_idle_pct = 30;
					recv_idle_pct = 60;
				end
				1: begin
					send_idle_pct = 60;
					recv_idle_pct = 30;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			plan_regs(k);
			apply_regs('1);
			run_events(PHASE_ITEMS);
			drain();
		end

		// long burst with a long receiver hold-off at the start
		plan_regs(RANDOM_PHASES);
		reg_plan[CFG_CYCLE_PERIOD] = '0;
		reg_plan[CFG_ACK_TIMEOUT] = '1;
		reg_plan[CFG_RESP_WAIT] = '0;
		reg_plan[CFG_REPEAT_LIMIT][7:0] = 8'd20;
		apply_regs('1);
		hold_asked++;
		start_cycles = sb.cycles_done;
		sent = 0;
		while (sb.cycles_done == start_cycles && sent < BIG_BURST_CAP) begin
			send_event(pick_event(1'b1));
			sent++;
		end
		drain();

		if (sb.errors == 0 && sb.cmds_due.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
